@@ design/ray_rect_diagonal_hit_top_assert.svh @@
// Assertion macros shared by the block's modules.
// Each use expands to one labelled concurrent assertion on clk, held off while rst_n is low.
`ifndef RAY_RECT_DIAGONAL_HIT_TOP_ASSERT_SVH
`define RAY_RECT_DIAGONAL_HIT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RRDH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrdh: same-cycle check failed");
`define RRDH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrdh: next-cycle check failed");
`else
`define RRDH_ASSERT_SAME(label, ante, cons)
`define RRDH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/rrdh_pkg.sv @@
`default_nettype none

package rrdh_pkg;

    localparam int COORD_W     = 10;
    localparam int HEAD_W      = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int NUM_PTS     = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [COORD_W-1:0] ORIGIN_X_RESET  = 10'd0;
    localparam logic [COORD_W-1:0] ORIGIN_Y_RESET  = 10'd0;
    localparam logic [HEAD_W-1:0]  HEADING_X_RESET = 11'd1;
    localparam logic [HEAD_W-1:0]  HEADING_Y_RESET = 11'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X  = 2'd0,
        CFG_ORIGIN_Y  = 2'd1,
        CFG_HEADING_X = 2'd2,
        CFG_HEADING_Y = 2'd3
    } rrdh_cfg_idx_t;

    typedef logic [COORD_W-1:0] rrdh_coord_t;

    // Points are ordered: both ends of the first diagonal, then both ends of the second.
    typedef struct packed {
        logic [NUM_PTS-1:0] on_span_ab;
        logic               a_in_rect;
        logic               b_in_rect;
    } rrdh_flags_t;

    typedef struct packed {
        rrdh_coord_t x1;
        rrdh_coord_t y1;
        rrdh_coord_t x2;
        rrdh_coord_t y2;
        logic        last;
        rrdh_flags_t flags;
    } rrdh_item_t;

endpackage

`default_nettype wire

@@ design/rrdh_cfg.sv @@
`default_nettype none

module rrdh_cfg #(
    parameter int COORD_LIMIT = 1024,
    localparam int END_W = $clog2(COORD_LIMIT + 1) + 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rrdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrdh_pkg::CFG_DATA_W-1:0] cfg_data,
    output rrdh_pkg::rrdh_coord_t          origin_x,
    output rrdh_pkg::rrdh_coord_t          origin_y,
    output logic signed [END_W-1:0]        end_x,
    output logic signed [END_W-1:0]        end_y
);
    import rrdh_pkg::*;

    localparam int CAP = $clog2(COORD_LIMIT + 1);
    localparam logic signed [END_W-1:0] LIMIT_S = $signed(END_W'(COORD_LIMIT));

    rrdh_coord_t              origin_x_reg;
    rrdh_coord_t              origin_y_reg;
    logic [HEAD_W-1:0]        heading_x_reg;
    logic [HEAD_W-1:0]        heading_y_reg;
    logic signed [END_W-1:0]  end_x_reg;
    logic signed [END_W-1:0]  end_y_reg;
    logic signed [END_W-1:0]  end_x_next;
    logic signed [END_W-1:0]  end_y_next;
    logic signed [END_W-1:0]  base_x;
    logic signed [END_W-1:0]  base_y;
    logic signed [END_W-1:0]  head_x;
    logic signed [END_W-1:0]  head_y;
    logic signed [END_W-1:0]  cand_x;
    logic signed [END_W-1:0]  cand_y;
    logic                     found;

    function automatic logic in_square(input logic signed [END_W-1:0] x,
                                       input logic signed [END_W-1:0] y);
        return !x[END_W-1] && (x < LIMIT_S) && !y[END_W-1] && (y < LIMIT_S);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= ORIGIN_X_RESET;
            origin_y_reg  <= ORIGIN_Y_RESET;
            heading_x_reg <= HEADING_X_RESET;
            heading_y_reg <= HEADING_Y_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (rrdh_cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X:  origin_x_reg  <= cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y:  origin_y_reg  <= cfg_data[COORD_W-1:0];
                CFG_HEADING_X: heading_x_reg <= cfg_data[HEAD_W-1:0];
                CFG_HEADING_Y: heading_y_reg <= cfg_data[HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Try every doubling in parallel, keep the first that leaves the square (or the cap).
    always_comb
    begin
        base_x = $signed({{(END_W-COORD_W){1'b0}}, origin_x_reg});
        base_y = $signed({{(END_W-COORD_W){1'b0}}, origin_y_reg});
        head_x = $signed({{(END_W-HEAD_W){heading_x_reg[HEAD_W-1]}}, heading_x_reg});
        head_y = $signed({{(END_W-HEAD_W){heading_y_reg[HEAD_W-1]}}, heading_y_reg});
        end_x_next = base_x + head_x;
        end_y_next = base_y + head_y;
        cand_x = end_x_next;
        cand_y = end_y_next;
        found = 1'b0;
        for (int k = 0; k <= CAP; k++)
        begin
            cand_x = base_x + (head_x <<< k);
            cand_y = base_y + (head_y <<< k);
            if (!found)
            begin
                end_x_next = cand_x;
                end_y_next = cand_y;
                if (!in_square(cand_x, cand_y) || (k == CAP))
                begin
                    found = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        end_x_reg <= end_x_next;
        end_y_reg <= end_y_next;
    end

    assign origin_x = origin_x_reg;
    assign origin_y = origin_y_reg;
    assign end_x    = end_x_reg;
    assign end_y    = end_y_reg;

endmodule

`default_nettype wire

@@ design/rrdh_front.sv @@
`default_nettype none

module rrdh_front #(
    parameter int COORD_LIMIT = 1024,
    localparam int END_W = $clog2(COORD_LIMIT + 1) + 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  rrdh_pkg::rrdh_coord_t   first_corner_x,
    input  rrdh_pkg::rrdh_coord_t   first_corner_y,
    input  rrdh_pkg::rrdh_coord_t   second_corner_x,
    input  rrdh_pkg::rrdh_coord_t   second_corner_y,
    input  logic                    last_in_case,
    input  rrdh_pkg::rrdh_coord_t   origin_x,
    input  rrdh_pkg::rrdh_coord_t   origin_y,
    input  logic signed [END_W-1:0] end_x,
    input  logic signed [END_W-1:0] end_y,
    input  logic                    q_full,
    output logic                    q_push,
    output rrdh_pkg::rrdh_item_t    q_item
);
    import rrdh_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic        load_en;
    rrdh_coord_t x1_reg;
    rrdh_coord_t y1_reg;
    rrdh_coord_t x2_reg;
    rrdh_coord_t y2_reg;
    logic        last_reg;

    logic signed [END_W-1:0] ax_w;
    logic signed [END_W-1:0] ay_w;
    logic signed [END_W-1:0] px_w [NUM_PTS];
    logic signed [END_W-1:0] py_w [NUM_PTS];
    logic signed [END_W-1:0] x1_w;
    logic signed [END_W-1:0] y1_w;
    logic signed [END_W-1:0] x2_w;
    logic signed [END_W-1:0] y2_w;
    rrdh_flags_t             flags;

    function automatic logic signed [END_W-1:0] widen(input rrdh_coord_t c);
        return $signed({{(END_W-COORD_W){1'b0}}, c});
    endfunction

    function automatic logic in_span(input logic signed [END_W-1:0] p,
                                     input logic signed [END_W-1:0] e1,
                                     input logic signed [END_W-1:0] e2);
        return !((p < e1) && (p < e2)) && !((p > e1) && (p > e2));
    endfunction

    // Hold the registered item while the queue is full.
    assign load_en  = !valid_reg || !q_full;
    assign in_stall = !load_en;
    assign q_push   = valid_reg && !q_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_en)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en && in_valid)
        begin
            x1_reg   <= first_corner_x;
            y1_reg   <= first_corner_y;
            x2_reg   <= second_corner_x;
            y2_reg   <= second_corner_y;
            last_reg <= last_in_case;
        end
    end

    // Bounding-box part of every on-segment test.
    always_comb
    begin
        ax_w = widen(origin_x);
        ay_w = widen(origin_y);
        x1_w = widen(x1_reg);
        y1_w = widen(y1_reg);
        x2_w = widen(x2_reg);
        y2_w = widen(y2_reg);
        px_w[0] = x1_w;
        py_w[0] = y1_w;
        px_w[1] = x2_w;
        py_w[1] = y2_w;
        px_w[2] = x1_w;
        py_w[2] = y2_w;
        px_w[3] = x2_w;
        py_w[3] = y1_w;
        for (int i = 0; i < NUM_PTS; i++)
        begin
            flags.on_span_ab[i] = in_span(px_w[i], ax_w, end_x) &&
                                  in_span(py_w[i], ay_w, end_y);
        end
        flags.a_in_rect = in_span(ax_w, x1_w, x2_w) && in_span(ay_w, y1_w, y2_w);
        flags.b_in_rect = in_span(end_x, x1_w, x2_w) && in_span(end_y, y1_w, y2_w);
    end

    always_comb
    begin
        q_item.x1    = x1_reg;
        q_item.y1    = y1_reg;
        q_item.x2    = x2_reg;
        q_item.y2    = y2_reg;
        q_item.last  = last_reg;
        q_item.flags = flags;
    end

endmodule

`default_nettype wire

@@ design/rrdh_queue.sv @@
`default_nettype none
`include "ray_rect_diagonal_hit_top_assert.svh"

module rrdh_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rrdh_pkg::rrdh_item_t item_in,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output rrdh_pkg::rrdh_item_t item_out
);
    import rrdh_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rrdh_item_t         entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign item_out = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= item_in;
        end
    end

    `RRDH_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `RRDH_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `RRDH_ASSERT_NEXT(a_count_hold, do_push && do_pop, count_reg == $past(count_reg))

endmodule

`default_nettype wire

@@ design/rrdh_back.sv @@
`default_nettype none
`include "ray_rect_diagonal_hit_top_assert.svh"

module rrdh_back #(
    parameter int COORD_LIMIT = 1024,
    localparam int END_W = $clog2(COORD_LIMIT + 1) + 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  rrdh_pkg::rrdh_item_t    q_item,
    output logic                    q_pop,
    input  rrdh_pkg::rrdh_coord_t   origin_x,
    input  rrdh_pkg::rrdh_coord_t   origin_y,
    input  logic signed [END_W-1:0] end_x,
    input  logic signed [END_W-1:0] end_y,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    hit,
    output logic                    last_out
);
    import rrdh_pkg::*;

    localparam int DW = END_W + 1;
    localparam int SW = COORD_W + 1;
    localparam int PW = DW + SW;
    localparam int CW = PW + 1;
    localparam int NUM_DIAG = NUM_PTS / 2;

    logic adv;

    // Product stage inputs
    logic signed [DW-1:0] ax_w;
    logic signed [DW-1:0] ay_w;
    logic signed [DW-1:0] bx_w;
    logic signed [DW-1:0] by_w;
    logic signed [DW-1:0] ex_w;
    logic signed [DW-1:0] ey_w;
    rrdh_coord_t          px [NUM_PTS];
    rrdh_coord_t          py [NUM_PTS];
    logic signed [SW-1:0] cax [NUM_PTS];
    logic signed [SW-1:0] cay [NUM_PTS];
    logic signed [SW-1:0] dcx [NUM_DIAG];
    logic signed [SW-1:0] dcy [NUM_DIAG];
    logic signed [DW-1:0] bcx [NUM_DIAG];
    logic signed [DW-1:0] bcy [NUM_DIAG];

    logic signed [PW-1:0] ab_a_next [NUM_PTS];
    logic signed [PW-1:0] ab_b_next [NUM_PTS];
    logic signed [PW-1:0] cda_a_next [NUM_DIAG];
    logic signed [PW-1:0] cda_b_next [NUM_DIAG];
    logic signed [PW-1:0] cdb_a_next [NUM_DIAG];
    logic signed [PW-1:0] cdb_b_next [NUM_DIAG];

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic signed [PW-1:0] s1_ab_a_reg [NUM_PTS];
    logic signed [PW-1:0] s1_ab_b_reg [NUM_PTS];
    logic signed [PW-1:0] s1_cda_a_reg [NUM_DIAG];
    logic signed [PW-1:0] s1_cda_b_reg [NUM_DIAG];
    logic signed [PW-1:0] s1_cdb_a_reg [NUM_DIAG];
    logic signed [PW-1:0] s1_cdb_b_reg [NUM_DIAG];
    rrdh_flags_t          s1_flags_reg;
    logic                 s1_last_reg;

    // Sign stage
    logic signed [CW-1:0] ab_x [NUM_PTS];
    logic signed [CW-1:0] cda_x [NUM_DIAG];
    logic signed [CW-1:0] cdb_x [NUM_DIAG];
    logic [NUM_PTS-1:0]   ab_zero;
    logic [NUM_PTS-1:0]   ab_neg;
    logic [NUM_DIAG-1:0]  cda_zero;
    logic [NUM_DIAG-1:0]  cda_neg;
    logic [NUM_DIAG-1:0]  cdb_zero;
    logic [NUM_DIAG-1:0]  cdb_neg;
    logic [NUM_DIAG-1:0]  meets;
    logic                 hit_next;

    logic out_valid_reg;
    logic out_valid_next;
    logic hit_reg;
    logic last_reg;

    function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] u,
                                                 input logic signed [SW-1:0] v);
        return u * v;
    endfunction

    function automatic logic signed [DW-1:0] widen_s(input logic signed [SW-1:0] v);
        return $signed({{(DW-SW){v[SW-1]}}, v});
    endfunction

    function automatic logic signed [CW-1:0] diff(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b);
        return $signed({a[PW-1], a}) - $signed({b[PW-1], b});
    endfunction

    function automatic logic opposite(input logic xz, input logic xn,
                                      input logic yz, input logic yn);
        return !xz && !yz && (xn != yn);
    endfunction

    // The whole back end moves together whenever the output register can take a result.
    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = adv && q_valid;

    always_comb
    begin
        ax_w = $signed({{(DW-COORD_W){1'b0}}, origin_x});
        ay_w = $signed({{(DW-COORD_W){1'b0}}, origin_y});
        bx_w = $signed({end_x[END_W-1], end_x});
        by_w = $signed({end_y[END_W-1], end_y});
        ex_w = bx_w - ax_w;
        ey_w = by_w - ay_w;
        px[0] = q_item.x1;
        py[0] = q_item.y1;
        px[1] = q_item.x2;
        py[1] = q_item.y2;
        px[2] = q_item.x1;
        py[2] = q_item.y2;
        px[3] = q_item.x2;
        py[3] = q_item.y1;
        for (int i = 0; i < NUM_PTS; i++)
        begin
            cax[i] = $signed({1'b0, px[i]}) - $signed({1'b0, origin_x});
            cay[i] = $signed({1'b0, py[i]}) - $signed({1'b0, origin_y});
            ab_a_next[i] = mul(ex_w, cay[i]);
            ab_b_next[i] = mul(ey_w, cax[i]);
        end
        for (int j = 0; j < NUM_DIAG; j++)
        begin
            dcx[j] = $signed({1'b0, px[2*j+1]}) - $signed({1'b0, px[2*j]});
            dcy[j] = $signed({1'b0, py[2*j+1]}) - $signed({1'b0, py[2*j]});
            bcx[j] = bx_w - $signed({{(DW-COORD_W){1'b0}}, px[2*j]});
            bcy[j] = by_w - $signed({{(DW-COORD_W){1'b0}}, py[2*j]});
            cda_a_next[j] = mul(widen_s(-cay[2*j]), dcx[j]);
            cda_b_next[j] = mul(widen_s(-cax[2*j]), dcy[j]);
            cdb_a_next[j] = mul(bcy[j], dcx[j]);
            cdb_b_next[j] = mul(bcx[j], dcy[j]);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (adv)
        begin
            s1_valid_next = q_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_ab_a_reg  <= ab_a_next;
            s1_ab_b_reg  <= ab_b_next;
            s1_cda_a_reg <= cda_a_next;
            s1_cda_b_reg <= cda_b_next;
            s1_cdb_a_reg <= cdb_a_next;
            s1_cdb_b_reg <= cdb_b_next;
            s1_flags_reg <= q_item.flags;
            s1_last_reg  <= q_item.last;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_PTS; i++)
        begin
            ab_x[i]    = diff(s1_ab_a_reg[i], s1_ab_b_reg[i]);
            ab_zero[i] = (ab_x[i] == '0);
            ab_neg[i]  = ab_x[i][CW-1];
        end
        for (int j = 0; j < NUM_DIAG; j++)
        begin
            cda_x[j]    = diff(s1_cda_a_reg[j], s1_cda_b_reg[j]);
            cdb_x[j]    = diff(s1_cdb_a_reg[j], s1_cdb_b_reg[j]);
            cda_zero[j] = (cda_x[j] == '0);
            cda_neg[j]  = cda_x[j][CW-1];
            cdb_zero[j] = (cdb_x[j] == '0);
            cdb_neg[j]  = cdb_x[j][CW-1];
            meets[j] = (ab_zero[2*j] && s1_flags_reg.on_span_ab[2*j]) ||
                       (ab_zero[2*j+1] && s1_flags_reg.on_span_ab[2*j+1]) ||
                       (cda_zero[j] && s1_flags_reg.a_in_rect) ||
                       (cdb_zero[j] && s1_flags_reg.b_in_rect) ||
                       (opposite(ab_zero[2*j], ab_neg[2*j], ab_zero[2*j+1], ab_neg[2*j+1]) &&
                        opposite(cda_zero[j], cda_neg[j], cdb_zero[j], cdb_neg[j]));
        end
        hit_next = |meets;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            hit_reg  <= hit_next;
            last_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign last_out  = last_reg;

    `RRDH_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !adv, s1_valid_reg && $stable(s1_last_reg))

endmodule

`default_nettype wire

@@ design/ray_rect_diagonal_hit_top.sv @@
// Throughput: one item per cycle while out_stall is low, set by the front register, the queue
// and the two-stage product/sign pipeline of the back end, each of which moves once per cycle.
// Reset (rst_n low, asynchronous): all valid flags and queue pointers clear, registers return
// to origin (0,0) and heading (1,0); the ray end register refreshes on every clock.
`default_nettype none

module ray_rect_diagonal_hit_top #(
    parameter int COORD_LIMIT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rrdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrdh_pkg::CFG_DATA_W-1:0] cfg_data,
    // Rectangle items
    input  logic                            in_valid,
    output logic                            in_stall,
    input  rrdh_pkg::rrdh_coord_t           first_corner_x,
    input  rrdh_pkg::rrdh_coord_t           first_corner_y,
    input  rrdh_pkg::rrdh_coord_t           second_corner_x,
    input  rrdh_pkg::rrdh_coord_t           second_corner_y,
    input  logic                            last_in_case,
    // Results
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic                            last_out
);
    import rrdh_pkg::*;

    localparam int END_W = $clog2(COORD_LIMIT + 1) + 12;

    rrdh_coord_t             origin_x;
    rrdh_coord_t             origin_y;
    logic signed [END_W-1:0] end_x;
    logic signed [END_W-1:0] end_y;
    logic                    q_push;
    logic                    q_full;
    logic                    q_pop;
    logic                    q_valid;
    rrdh_item_t              q_item_in;
    rrdh_item_t              q_item_out;

    // Configuration registers and the far end of the ray. The end point is found by
    // testing every doubling of the heading in parallel and taking the first one that
    // leaves the square, or the shift cap.
    rrdh_cfg #(
        .COORD_LIMIT (COORD_LIMIT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .end_x     (end_x),
        .end_y     (end_y)
    );

    // Front: register each transfer, build the second diagonal and work out the
    // bounding-box part of every on-segment test.
    rrdh_front #(
        .COORD_LIMIT (COORD_LIMIT)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .first_corner_x  (first_corner_x),
        .first_corner_y  (first_corner_y),
        .second_corner_x (second_corner_x),
        .second_corner_y (second_corner_y),
        .last_in_case    (last_in_case),
        .origin_x        (origin_x),
        .origin_y        (origin_y),
        .end_x           (end_x),
        .end_y           (end_y),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (q_item_in)
    );

    // Short queue: the front keeps taking items while the back waits on out_stall.
    rrdh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (q_item_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .item_out (q_item_out)
    );

    // Back: sixteen products in one stage, then the eight cross-product signs, the
    // straddle and touch tests, and the output register.
    rrdh_back #(
        .COORD_LIMIT (COORD_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item_out),
        .q_pop     (q_pop),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .last_out  (last_out)
    );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none

module tb_top;

    import rrdh_pkg::*;

    // Size of the coordinate square; the block is built with its default.
    localparam longint SQUARE        = 1024;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     HOLDOFF_LEN   = 80;
    localparam int     HOLDOFF_AT    = 40;
    localparam int     CALM_FROM     = 200;
    localparam int     CALM_TO       = 280;

    typedef struct packed {
        rrdh_coord_t x1;
        rrdh_coord_t y1;
        rrdh_coord_t x2;
        rrdh_coord_t y2;
        logic        last;
    } rect_t;

    typedef struct packed {
        logic hit;
        logic last;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    rrdh_coord_t first_corner_x = '0;
    rrdh_coord_t first_corner_y = '0;
    rrdh_coord_t second_corner_x = '0;
    rrdh_coord_t second_corner_y = '0;
    logic        last_in_case = 1'b0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic last_out;

    // Local copy of the ray registers, updated on each configuration transfer.
    rrdh_coord_t              ray_origin_x = ORIGIN_X_RESET;
    rrdh_coord_t              ray_origin_y = ORIGIN_Y_RESET;
    logic signed [HEAD_W-1:0] ray_heading_x = HEADING_X_RESET;
    logic signed [HEAD_W-1:0] ray_heading_y = HEADING_Y_RESET;

    rect_t    rects_to_send[$];
    verdict_t expected_verdicts[$];

    int  queued_count = 0;
    int  accepted_count = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  in_fire = 1'b0;
    int  holdoff_left = 0;
    bit  holdoff_done = 1'b0;

    ray_rect_diagonal_hit_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .first_corner_x  (first_corner_x),
        .first_corner_y  (first_corner_y),
        .second_corner_x (second_corner_x),
        .second_corner_y (second_corner_y),
        .last_in_case    (last_in_case),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .last_out        (last_out)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Geometry predictor
    // ------------------------------------------------------------------

    function automatic longint orient(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
        return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    endfunction

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Point p lies on segment a-b: collinear and within the bounding box.
    function automatic bit point_on_span(longint ax, longint ay, longint bx, longint by,
                                         longint px, longint py);
        if (orient(ax, ay, bx, by, px, py) != 0)
            return 1'b0;
        if (px < ax && px < bx) return 1'b0;
        if (px > ax && px > bx) return 1'b0;
        if (py < ay && py < by) return 1'b0;
        if (py > ay && py > by) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit straddle(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy, longint dx, longint dy);
        return sign_of(orient(ax, ay, bx, by, cx, cy))
             * sign_of(orient(ax, ay, bx, by, dx, dy)) < 0;
    endfunction

    // Touching, endpoints on the other segment and collinear overlap all count.
    function automatic bit segments_meet(longint ax, longint ay, longint bx, longint by,
                                         longint cx, longint cy, longint dx, longint dy);
        if (point_on_span(ax, ay, bx, by, cx, cy) || point_on_span(ax, ay, bx, by, dx, dy))
            return 1'b1;
        if (point_on_span(cx, cy, dx, dy, ax, ay) || point_on_span(cx, cy, dx, dy, bx, by))
            return 1'b1;
        return straddle(ax, ay, bx, by, cx, cy, dx, dy)
            && straddle(cx, cy, dx, dy, ax, ay, bx, by);
    endfunction

    function automatic bit in_square(longint x, longint y);
        return x >= 0 && x < SQUARE && y >= 0 && y < SQUARE;
    endfunction

    // Stretch the heading by doubling until the end leaves the square, stopping at the
    // first shift whose power of two exceeds the square size.
    function automatic void ray_far_end(output longint ex, output longint ey);
        longint hx;
        longint hy;
        int     shift_cap;
        int     k;
        hx = longint'(ray_heading_x);
        hy = longint'(ray_heading_y);
        shift_cap = 0;
        while ((longint'(1) << shift_cap) <= SQUARE)
            shift_cap++;
        k = 0;
        forever
        begin
            ex = longint'(ray_origin_x) + hx * (longint'(1) << k);
            ey = longint'(ray_origin_y) + hy * (longint'(1) << k);
            if (!in_square(ex, ey) || k >= shift_cap)
                break;
            k++;
        end
    endfunction

    function automatic logic predict_hit(rect_t r);
        longint ax;
        longint ay;
        longint bx;
        longint by;
        ax = longint'(ray_origin_x);
        ay = longint'(ray_origin_y);
        ray_far_end(bx, by);
        // Main diagonal, then the cross diagonal.
        return segments_meet(ax, ay, bx, by, longint'(r.x1), longint'(r.y1),
                             longint'(r.x2), longint'(r.y2))
            || segments_meet(ax, ay, bx, by, longint'(r.x1), longint'(r.y2),
                             longint'(r.x2), longint'(r.y1));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic rrdh_coord_t clamp_coord(longint v);
        if (v < 0)
            return '0;
        if (v >= SQUARE)
            return rrdh_coord_t'(SQUARE - 1);
        return rrdh_coord_t'(v);
    endfunction

    // Most rectangles sit on or close to the ray so that hits, touches and near misses
    // all come up; the rest are spread over the whole square or pinned to the origin.
    function automatic rect_t make_rect();
        rect_t       r;
        rrdh_coord_t tmp;
        longint      bx;
        longint      by;
        longint      px;
        longint      py;
        int          pick;
        int          t;
        ray_far_end(bx, by);
        pick = $urandom_range(99);
        t = $urandom_range(1000);
        px = longint'(ray_origin_x) + (bx - longint'(ray_origin_x)) * t / 1000;
        py = longint'(ray_origin_y) + (by - longint'(ray_origin_y)) * t / 1000;
        r.last = ($urandom_range(3) == 0);
        r.x1 = rrdh_coord_t'($urandom_range(1023));
        r.y1 = rrdh_coord_t'($urandom_range(1023));
        r.x2 = rrdh_coord_t'($urandom_range(1023));
        r.y2 = rrdh_coord_t'($urandom_range(1023));
        if (pick < 20)
            return r;
        if (pick < 30)
        begin
            r.x1 = ray_origin_x;
            r.y1 = ray_origin_y;
            return r;
        end
        r.x1 = clamp_coord(px - longint'($urandom_range(40)));
        r.y1 = clamp_coord(py - longint'($urandom_range(40)));
        r.x2 = clamp_coord(px + longint'($urandom_range(40)));
        r.y2 = clamp_coord(py + longint'($urandom_range(40)));
        if (pick < 45)
            r.x2 = r.x1;
        else if (pick < 55)
            r.y2 = r.y1;
        if ($urandom_range(1) == 1)
        begin
            tmp = r.x1;
            r.x1 = r.x2;
            r.x2 = tmp;
        end
        return r;
    endfunction

    task automatic queue_rect(input int x1, input int y1, input int x2, input int y2,
                              input bit last);
        rect_t r;
        r.x1 = rrdh_coord_t'(x1);
        r.y1 = rrdh_coord_t'(y1);
        r.x2 = rrdh_coord_t'(x2);
        r.y2 = rrdh_coord_t'(y2);
        r.last = last;
        rects_to_send.push_back(r);
        queued_count++;
    endtask

    task automatic queue_random(input int n);
        repeat (n)
        begin
            rects_to_send.push_back(make_rect());
            queued_count++;
        end
    endtask

    // Wait until every queued rectangle has been taken and answered, then let the
    // pipeline settle before the registers move.
    task automatic wait_idle();
        do @(negedge clk);
        while (!(accepted_count == queued_count && expected_verdicts.size() == 0));
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input rrdh_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ORIGIN_X:  ray_origin_x  = value[COORD_W-1:0];
            CFG_ORIGIN_Y:  ray_origin_y  = value[COORD_W-1:0];
            CFG_HEADING_X: ray_heading_x = value;
            CFG_HEADING_Y: ray_heading_y = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Origin writes carry a random spare top bit, which the block must drop.
    task automatic set_ray(input int ox, input int oy, input int hx, input int hy);
        wait_idle();
        write_reg(CFG_ORIGIN_X, {1'($urandom_range(1)), COORD_W'(ox)});
        write_reg(CFG_ORIGIN_Y, {1'($urandom_range(1)), COORD_W'(oy)});
        write_reg(CFG_HEADING_X, HEAD_W'(hx));
        write_reg(CFG_HEADING_Y, HEAD_W'(hy));
    endtask

    function automatic int random_heading();
        if ($urandom_range(3) == 0)
            return 0;
        if ($urandom_range(1) == 0)
            return $urandom_range(16) - 8;
        return $urandom_range(2047);
    endfunction

    function automatic bit calm_stretch();
        return accepted_count >= CALM_FROM && accepted_count < CALM_TO;
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("MISMATCH result %0d: %s got %b expected %b at cycle %0d",
                 accepted_count, what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: present the next rectangle once the previous one has transferred,
    // idling at random except through the calm stretch.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        rect_t nxt;
        if (!in_valid || in_fire)
        begin
            if (rects_to_send.size() > 0 && (calm_stretch() || $urandom_range(99) >= 34))
            begin
                nxt = rects_to_send.pop_front();
                first_corner_x  <= nxt.x1;
                first_corner_y  <= nxt.y1;
                second_corner_x <= nxt.x2;
                second_corner_y <= nxt.y2;
                last_in_case    <= nxt.last;
                in_valid        <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall at random, and once hold off for a long stretch while the
    // sender keeps offering so that the block backs up and stalls its input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_stall <= 1'b1;
        end
        else if (!holdoff_done && accepted_count >= HOLDOFF_AT)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_LEN - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm_stretch() && ($urandom_range(99) < 34);
    end

    // ------------------------------------------------------------------
    // Sample both channels at the rising edge: predict on each input transfer,
    // check each result transfer against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rect_t    r;
        verdict_t want;
        in_fire = in_valid && !in_stall;
        if (in_fire)
        begin
            r.x1 = first_corner_x;
            r.y1 = first_corner_y;
            r.x2 = second_corner_x;
            r.y2 = second_corner_y;
            r.last = last_in_case;
            want.hit = predict_hit(r);
            want.last = r.last;
            expected_verdicts.push_back(want);
            accepted_count++;
        end
        if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch("unexpected out_valid", out_valid, 1'b0);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", hit, want.hit);
                if (last_out !== want.last)
                    report_mismatch("last_out", last_out, want.last);
            end
        end
    end

    // Drop the run if it stops making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Phases
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset ray: origin (0,0), heading (1,0), so the segment runs along y = 0
        // out to x = 1024.
        queue_rect(0, 0, 1023, 1023, 1'b0);     // diagonal starts at the origin
        queue_rect(1023, 1023, 0, 0, 1'b0);     // same, corners swapped
        queue_rect(5, 0, 5, 0, 1'b0);           // point rectangle on the ray
        queue_rect(5, 1, 5, 1, 1'b0);           // point rectangle just off it
        queue_rect(10, 0, 20, 0, 1'b0);         // flat rectangle, collinear overlap
        queue_rect(10, 1, 20, 5, 1'b0);         // clear miss above the ray
        queue_rect(1023, 0, 1023, 1023, 1'b0);  // thin edge touching the ray
        queue_rect(0, 1023, 1023, 1023, 1'b0);  // top edge, miss
        queue_rect(100, 5, 200, 0, 1'b0);       // cross diagonal ends on the ray
        queue_rect(0, 0, 0, 0, 1'b1);           // point at the origin itself

        // Zero heading: the segment shrinks to the origin point.
        set_ray(100, 200, 0, 0);
        queue_rect(0, 100, 200, 300, 1'b0);     // diagonal through the point
        queue_rect(100, 200, 100, 200, 1'b0);
        queue_rect(101, 200, 101, 200, 1'b0);
        queue_rect(50, 200, 150, 200, 1'b0);
        queue_rect(0, 0, 1023, 1023, 1'b1);
        queue_random(30);

        set_ray(512, 512, 3, -5);
        queue_random(70);

        // Far corner with the most negative heading: the first step already leaves.
        set_ray(1023, 1023, -1024, -1023);
        queue_random(40);

        set_ray(0, 1023, 1023, 0);
        queue_random(40);

        repeat (5)
        begin
            set_ray($urandom_range(1023), $urandom_range(1023),
                    random_heading(), random_heading());
            queue_random(45);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+design
design/rrdh_pkg.sv
design/rrdh_cfg.sv
design/rrdh_front.sv
design/rrdh_queue.sv
design/rrdh_back.sv
design/ray_rect_diagonal_hit_top.sv
dv/tb_top.sv
